@@ design/mpr_pkg.sv @@
// Shared types and constants for the Ryser permanent block.
`timescale 1ns / 1ps
package mpr_pkg;

   localparam int MPR_MAX_SIZE      = 8;
   localparam int MPR_FRACTION_BITS = 16;

   localparam int ENTRY_W    = 18;
   localparam int PERM_W     = 64;
   localparam int ROW_IDX_W  = 3;
   localparam int COL_IDX_W  = 3;
   localparam int REQ_DATA_W = 24;
   localparam int SIZE_W     = 4;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;
   localparam logic [PERM_W-1:0] POS_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [PERM_W-1:0] NEG_MAX    = 64'h8000_0000_0000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_PROD,
      ST_MUL_WAIT,
      ST_ACCUM,
      ST_ROW,
      ST_DRAIN,
      ST_FINAL
   } mpr_state_type;

   typedef struct packed {
      logic clear;
      logic update;
      logic subtract;
   } mpr_colsum_ctl_type;

endpackage

@@ design/matrix_permanent_ryser.sv @@
// Top level of the Ryser permanent block: store, sequencer, result register.
//
//  Channel | Direction | Handshake                 | Contents
//  req_    | in        | req_tvalid / req_tready   | one matrix entry, compute flag in tuser
//  rsp_    | out       | rsp_tvalid / rsp_tready   | permanent, saturation flag in tuser
//  csr_    | in        | APB, pready tied high     | matrix_size, paddr not decoded
//
//  An entry without the compute flag is written to the store and req_tready stays high.
//  A compute's length is set by the one shared multiplier (one product per column per
//  subset) and by the column sum update, one store read per changed row and column.
//  req_tready is low during a compute; the result register frees the input side
//  again once the permanent is loaded, even while rsp_tready is low.
//  Reset clears the control state; the matrix store holds nothing until written.
`timescale 1ns / 1ps
module matrix_permanent_ryser #(
   parameter int MAX_SIZE = mpr_pkg::MPR_MAX_SIZE,
   parameter int FRACTION_BITS = mpr_pkg::MPR_FRACTION_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [2:0] row_index, [5:3] col_index, [23:6] entry_value
   input  logic [mpr_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] compute_now
   input  logic [0:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [63:0] permanent_value
   output logic [mpr_pkg::PERM_W-1:0]         rsp_tdata,
   // [0] saturated
   output logic [0:0]                         rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mpr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mpr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mpr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import mpr_pkg::*;

   localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_W  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int NW     = $clog2(MAX_SIZE + 1);
   localparam int CSUM_W = ENTRY_W + $clog2(MAX_SIZE);
   localparam logic [PERM_W-1:0] ONE = PERM_W'(1) << FRACTION_BITS;
   localparam logic [MAX_SIZE-1:0] ALL_ONES = {MAX_SIZE{1'b1}};

   mpr_state_type state_ff, state_in;

   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [NW-1:0]       n_ff, n_in;
   logic [MAX_SIZE-1:0] subset_ff, subset_in;
   logic [IDX_W-1:0]    row_ff, row_in;
   logic [NW-1:0]       col_ff, col_in;
   logic                parity_ff, parity_in;
   logic [PERM_W-1:0]   prod_ff, prod_in;
   logic [PERM_W-1:0]   total_ff, total_in;
   logic                sat_ff, sat_in;
   logic                rd_v_ff, rd_v_in;
   logic [IDX_W-1:0]    rd_col_ff, rd_col_in;
   logic                rd_sub_ff, rd_sub_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PERM_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_sat_ff, rsp_sat_in;

   logic                 req_accept;
   logic                 csr_write;
   logic [ROW_IDX_W-1:0] req_row;
   logic [COL_IDX_W-1:0] req_col;
   logic [ENTRY_W-1:0]   req_entry;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ENTRY_W-1:0]   rd_data;
   logic [NW-1:0]        n_eff;
   logic [MAX_SIZE-1:0]  subset_mask;
   logic                 last_col;
   logic                 last_subset;
   logic                 row_bit;
   logic                 out_free;
   logic                 mul_start;
   logic                 mul_done;
   logic [PERM_W-1:0]    mul_result;
   logic                 mul_sat;
   logic signed [CSUM_W-1:0] csum_rd;
   mpr_colsum_ctl_type   cs_ctl;
   logic [PERM_W-1:0]    acc_b;
   logic [PERM_W-1:0]    acc_sum;
   logic                 acc_ovf;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = CSR_DATA_W'(size_ff);
   assign size_in    = csr_write ? csr_pwdata[SIZE_W-1:0] : size_ff;

   // Request decode and store write
   assign req_accept = req_tvalid & req_tready;
   assign req_row    = req_tdata[ROW_IDX_W-1:0];
   assign req_col    = req_tdata[ROW_IDX_W +: COL_IDX_W];
   assign req_entry  = req_tdata[ROW_IDX_W + COL_IDX_W +: ENTRY_W];
   assign wr_en      = req_accept & (32'(req_row) < MAX_SIZE) & (32'(req_col) < MAX_SIZE);
   assign wr_addr    = ADDR_W'(ADDR_W'(req_row) * ADDR_W'(MAX_SIZE) + ADDR_W'(req_col));
   assign rd_addr    = ADDR_W'(ADDR_W'(row_ff) * ADDR_W'(MAX_SIZE) + ADDR_W'(col_ff));

   assign n_eff       = (32'(size_ff) > MAX_SIZE) ? NW'(MAX_SIZE) : NW'(size_ff);
   assign subset_mask = ~(ALL_ONES << n_ff);
   assign last_col    = (col_ff == n_ff - NW'(1));
   assign last_subset = (subset_ff == subset_mask);
   assign row_bit     = subset_ff[row_ff];
   assign out_free    = !rsp_valid_ff || rsp_tready;

   // Signed add or subtract of the product with saturation
   assign acc_b   = parity_ff ? ~prod_ff : prod_ff;
   assign acc_sum = total_ff + acc_b + PERM_W'(parity_ff);
   assign acc_ovf = (total_ff[PERM_W-1] == acc_b[PERM_W-1]) &&
                    (acc_sum[PERM_W-1] != total_ff[PERM_W-1]);

   mpr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_mpr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mpr_colsum #(
      .MAX_SIZE (MAX_SIZE),
      .CSUM_W   (CSUM_W),
      .IDX_W    (IDX_W)
   ) u_mpr_colsum (
      .clock     (clock),
      .ctl       (cs_ctl),
      .upd_col   (rd_col_ff),
      .upd_value (rd_data),
      .rd_col    (col_ff[IDX_W-1:0]),
      .rd_value  (csum_rd)
   );

   mpr_fxmul #(
      .FRACTION_BITS (FRACTION_BITS),
      .CSUM_W        (CSUM_W)
   ) u_mpr_fxmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a_value (prod_ff),
      .b_value (csum_rd),
      .done    (mul_done),
      .result  (mul_result),
      .sat     (mul_sat)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_tuser[0]) begin
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: state_in = ST_PROD;
         ST_PROD: begin
            state_in = (col_ff == n_ff) ? ST_ACCUM : ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (mul_done) begin
               state_in = ST_PROD;
            end
         end
         ST_ACCUM: begin
            state_in = last_subset ? ST_FINAL : ST_ROW;
         end
         ST_ROW: begin
            if (last_col && row_bit) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_PROD;
         ST_FINAL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      req_tready = 1'b0;
      mul_start  = 1'b0;
      rd_v_in    = 1'b0;
      cs_ctl     = '{clear: 1'b0, update: rd_v_ff, subtract: rd_sub_ff};
      unique case (state_ff) inside
         ST_IDLE:     req_tready = 1'b1;
         ST_CLEAR:    cs_ctl.clear = 1'b1;
         ST_PROD:     mul_start = (col_ff != n_ff);
         ST_ROW:      rd_v_in = 1'b1;
         ST_MUL_WAIT, ST_ACCUM, ST_DRAIN, ST_FINAL: begin
         end
         default: begin
         end
      endcase
   end

   assign rd_col_in = col_ff[IDX_W-1:0];
   assign rd_sub_in = !row_bit;

   // Datapath
   always_comb begin
      n_in         = n_ff;
      subset_in    = subset_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      parity_in    = parity_ff;
      prod_in      = prod_ff;
      total_in     = total_ff;
      sat_in       = sat_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            n_in      = n_eff;
            subset_in = '0;
            row_in    = '0;
            col_in    = '0;
            parity_in = 1'b0;
            prod_in   = ONE;
            total_in  = '0;
            sat_in    = 1'b0;
         end
         ST_MUL_WAIT: begin
            if (mul_done) begin
               prod_in = mul_result;
               sat_in  = sat_ff | mul_sat;
               col_in  = col_ff + NW'(1);
            end
         end
         ST_ACCUM: begin
            total_in  = acc_ovf ? (total_ff[PERM_W-1] ? NEG_MAX : POS_MAX) : acc_sum;
            sat_in    = sat_ff | acc_ovf;
            prod_in   = ONE;
            subset_in = subset_ff + MAX_SIZE'(1);
            row_in    = '0;
            col_in    = '0;
         end
         ST_ROW: begin
            if (last_col) begin
               col_in    = '0;
               parity_in = !parity_ff;
               if (!row_bit) begin
                  row_in = row_ff + IDX_W'(1);
               end
            end else begin
               col_in = col_ff + NW'(1);
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sat_in   = sat_ff;
               rsp_data_in  = total_ff;
               if (n_ff[0]) begin
                  if (total_ff == NEG_MAX) begin
                     rsp_data_in = POS_MAX;
                     rsp_sat_in  = 1'b1;
                  end else begin
                     rsp_data_in = PERM_W'(0) - total_ff;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= SIZE_RESET;
         rd_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         rd_v_ff      <= rd_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      subset_ff   <= subset_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      parity_ff   <= parity_in;
      prod_ff     <= prod_in;
      total_ff    <= total_in;
      sat_ff      <= sat_in;
      rd_col_ff   <= rd_col_in;
      rd_sub_ff   <= rd_sub_in;
      rsp_data_ff <= rsp_data_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

endmodule

@@ design/mpr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mpr_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/mpr_colsum.sv @@
// Column sum registers, updated one column a cycle while ctl.update is set.
`timescale 1ns / 1ps
module mpr_colsum #(
   parameter int MAX_SIZE = 8,
   parameter int CSUM_W = 21,
   parameter int IDX_W = 3
) (
   input  logic                                clock,
   input  mpr_pkg::mpr_colsum_ctl_type         ctl,
   input  logic [IDX_W-1:0]                    upd_col,
   input  logic signed [mpr_pkg::ENTRY_W-1:0]  upd_value,
   input  logic [IDX_W-1:0]                    rd_col,
   output logic signed [CSUM_W-1:0]            rd_value
);
   import mpr_pkg::*;

   logic signed [CSUM_W-1:0] csum_ff [MAX_SIZE];
   logic signed [CSUM_W-1:0] csum_in [MAX_SIZE];
   logic signed [CSUM_W-1:0] ext_value;

   assign ext_value = CSUM_W'(upd_value);

   always_comb begin
      for (int i = 0; i < MAX_SIZE; i++) begin
         csum_in[i] = ctl.clear ? '0 : csum_ff[i];
      end
      if (!ctl.clear && ctl.update) begin
         if (ctl.subtract) begin
            csum_in[upd_col] = csum_ff[upd_col] - ext_value;
         end else begin
            csum_in[upd_col] = csum_ff[upd_col] + ext_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_SIZE; i++) begin
         csum_ff[i] <= csum_in[i];
      end
   end

   assign rd_value = csum_ff[rd_col];

endmodule

@@ design/mpr_fxmul.sv @@
// Shared fixed-point multiplier: two partial products, round, saturate.
`timescale 1ns / 1ps
module mpr_fxmul #(
   parameter int FRACTION_BITS = 16,
   parameter int CSUM_W = 21
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [mpr_pkg::PERM_W-1:0]        a_value,
   input  logic signed [CSUM_W-1:0]          b_value,
   output logic                              done,
   output logic [mpr_pkg::PERM_W-1:0]        result,
   output logic                              sat
);
   import mpr_pkg::*;

   localparam int PART_W = 32 + CSUM_W;
   localparam int ACC_W  = PERM_W + CSUM_W;
   localparam int QSRC_W = ACC_W - FRACTION_BITS;
   localparam int QW     = (QSRC_W > 65) ? QSRC_W : 65;
   localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (FRACTION_BITS - 1);

   logic [4:0]        stage_ff, stage_in;
   logic [PERM_W-1:0] ma_ff, ma_in;
   logic [CSUM_W-1:0] mb_ff, mb_in;
   logic              neg_ff, neg_in;
   logic [PART_W-1:0] part_ff, part_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [PERM_W-1:0] res_ff, res_in;
   logic              sat_ff, sat_in;
   logic [31:0]       mul_a;
   logic [QW-1:0]     q;
   logic              q_ovf;

   always_comb begin
      stage_in = {stage_ff[3:0], start};
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      neg_in   = neg_ff;
      if (start) begin
         ma_in  = a_value[PERM_W-1] ? PERM_W'(0) - a_value : a_value;
         mb_in  = b_value[CSUM_W-1] ? CSUM_W'(0) - b_value : b_value;
         neg_in = a_value[PERM_W-1] ^ b_value[CSUM_W-1];
      end
   end

   assign mul_a   = stage_ff[0] ? ma_ff[31:0] : ma_ff[63:32];
   assign part_in = PART_W'(mul_a) * PART_W'(mb_ff);

   assign q     = QW'(acc_ff >> FRACTION_BITS);
   assign q_ovf = (|q[QW-1:PERM_W]) | (q[PERM_W-1] & (!neg_ff | (|q[PERM_W-2:0])));

   always_comb begin
      acc_in = acc_ff;
      if (stage_ff[1]) begin
         acc_in = ACC_W'(part_ff) + ROUND;
      end else if (stage_ff[2]) begin
         acc_in = acc_ff + (ACC_W'(part_ff) << 32);
      end
      res_in = res_ff;
      sat_in = sat_ff;
      if (stage_ff[3]) begin
         sat_in = q_ovf;
         if (q_ovf) begin
            res_in = neg_ff ? NEG_MAX : POS_MAX;
         end else begin
            res_in = neg_ff ? PERM_W'(0) - q[PERM_W-1:0] : q[PERM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      neg_ff  <= neg_in;
      part_ff <= part_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
      sat_ff  <= sat_in;
   end

   assign done   = stage_ff[4];
   assign result = res_ff;
   assign sat    = sat_ff;

endmodule

@@ design/mpr_checker.sv @@
// Port-level checks for the Ryser permanent block, bound to the top level.
`timescale 1ns / 1ps
module mpr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [0:0]                     req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [mpr_pkg::PERM_W-1:0]     rsp_tdata
);
   import mpr_pkg::*;

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result dropped or changed");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared without a compute");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser[0] |=> req_tready)
      else $error("plain entry request stalled the input");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] |=> !req_tready)
      else $error("compute request did not hold off the input");

endmodule

bind matrix_permanent_ryser mpr_checker u_mpr_checker (.*);
